// File: hw/rtl/danf_pkg.sv
// Shared constants, types and helpers for the decimal ASCII number formatter.
package danf_pkg;

	localparam int DEF_MAX_DIGITS = 10;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 4;
	localparam int CHAR_W  = 8;
	localparam int POS_W   = 4;
	localparam int DIGIT_W = 4;

	// floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
	localparam int                 DIV10_SHIFT = 35;

	// floor(f / 10) == (f * DIV10_SMALL_MUL) >> DIV10_SMALL_SHIFT for f below 1029
	localparam logic [7:0] DIV10_SMALL_MUL   = 8'd205;
	localparam int         DIV10_SMALL_SHIFT = 11;

	localparam logic [6:0] FRAC_SCALE = 7'd100;
	localparam int         FRAC_SHIFT = 8;
	localparam int         FIXED_LEN  = 5;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Side information that travels with a number down the pipeline
	typedef struct packed {
		logic               fmt;
		logic [COUNT_W-1:0] cnt;
		digit_t             ftens;
		digit_t             fones;
	} meta_t;

	function automatic logic [CHAR_W-1:0] to_char(input digit_t d);
		return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
	endfunction

	// Low four bits of q * 10, enough to recover a remainder below ten
	function automatic digit_t times10_lo(input digit_t q);
		return {q[0], 3'b000} + {q[2:0], 1'b0};
	endfunction

endpackage

// File: hw/rtl/decimal_ascii_number_formatter_top.sv
// Decimal ASCII number formatter: digit extraction pipeline and character serializer.
//
// A number is taken at a rising edge where start is high and busy is low. It runs
// through a capture stage, one divide-by-ten stage per digit (a reciprocal
// multiply each) and the serializer registers before its first character shows on
// the result ports. The characters then leave one beat per cycle, most significant
// first, each marked by strobe for exactly one cycle, with position counting from
// zero and last set on the final beat. The receiver cannot hold results off, so the
// block never waits on it. A number occupies the single-character output for
// digit_count beats (saturated to MAX_DIGITS) in integer format and five beats
// ("NN.NN") in fixed format, so the output serializer sets the sustained number
// rate. While the serializer still owns more beats of an earlier number the whole
// pipeline holds and busy is high; the pipeline itself takes a number in every
// cycle in which busy is low. A number in integer format with a digit count of
// zero yields no beats at all and is dropped at the serializer without delay.
module decimal_ascii_number_formatter_top
	import danf_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               format,
	input  logic [VALUE_W-1:0] value,
	input  logic [COUNT_W-1:0] digit_count,
	output logic               strobe,
	output logic [CHAR_W-1:0]  character,
	output logic [POS_W-1:0]   position,
	output logic               last
);

	// Digits produced by the chain: fixed format always needs two integer digits
	localparam int ND    = (MAX_DIGITS > 2) ? MAX_DIGITS : 2;
	localparam int SER_N = (ND > FIXED_LEN) ? ND : FIXED_LEN;
	localparam int PTR_W = $clog2(SER_N);

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

	// Pipeline stage registers: index 0 is the capture stage, k holds k digits
	logic                   vld_s  [0:ND];
	logic [VALUE_W-1:0]     x_s    [0:ND];
	logic [ND-1:0][DIGIT_W-1:0] dig_s [0:ND];
	meta_t                  meta_s [0:ND];
	logic [14:0]            fprod_s0;

	// Serializer registers
	logic                   ser_busy_q;
	logic [PTR_W-1:0]       ser_ptr_q;
	logic [POS_W-1:0]       ser_pos_q;
	logic [CHAR_W-1:0]      chr_q [0:SER_N-1];

	logic                   adv;
	logic                   emit;
	logic [COUNT_W-1:0]     cnt_sat;

	// Advance the whole pipeline whenever the serializer is free or on its last beat
	assign adv  = !ser_busy_q || (ser_ptr_q == '0);
	assign busy = !adv;

	assign cnt_sat = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;

	// Capture stage: fixed format converts the integer part, value >> 8
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]          <= format ? {{FRAC_SHIFT{1'b0}}, value[VALUE_W-1:FRAC_SHIFT]} : value;
			dig_s[0]        <= '0;
			meta_s[0].fmt   <= format;
			meta_s[0].cnt   <= cnt_sat;
			meta_s[0].ftens <= '0;
			meta_s[0].fones <= '0;
			fprod_s0        <= 15'(value[FRAC_SHIFT-1:0]) * 15'(FRAC_SCALE);
		end
	end

	// Divide-by-ten stages: one reciprocal multiply each, remainder is the next digit
	for (genvar k = 1; k <= ND; k++) begin : g_div
		logic [2*VALUE_W-1:0] prod;
		logic [VALUE_W-1:0]   quo;
		digit_t               rem;
		meta_t                meta_nxt;
		logic [ND-1:0][DIGIT_W-1:0] dig_nxt;
		logic [6:0]           frac;
		logic [14:0]          fprod10;
		digit_t               ften;

		assign prod = {{VALUE_W{1'b0}}, x_s[k-1]} * {{VALUE_W{1'b0}}, DIV10_MUL};
		assign quo  = {{(DIV10_SHIFT-VALUE_W){1'b0}}, prod[2*VALUE_W-1:DIV10_SHIFT]};
		assign rem  = x_s[k-1][DIGIT_W-1:0] - times10_lo(quo[DIGIT_W-1:0]);

		// The first stage also splits the two fraction digits
		assign frac    = fprod_s0[14:FRAC_SHIFT];
		assign fprod10 = 15'(frac) * 15'(DIV10_SMALL_MUL);
		assign ften    = fprod10[DIV10_SMALL_SHIFT+DIGIT_W-1:DIV10_SMALL_SHIFT];

		always_comb begin
			meta_nxt       = meta_s[k-1];
			dig_nxt        = dig_s[k-1];
			dig_nxt[k-1]   = rem;
			if (k == 1) begin
				meta_nxt.ftens = ften;
				meta_nxt.fones = frac[DIGIT_W-1:0] - times10_lo(ften);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[k]    <= quo;
				dig_s[k]  <= dig_nxt;
				meta_s[k] <= meta_nxt;
			end
		end
	end

	// Drop integer-format numbers that ask for no digits
	assign emit = meta_s[ND].fmt || (meta_s[ND].cnt != '0);

	// Serializer: load the character row, then walk it down from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy_q <= 1'b0;
			ser_ptr_q  <= '0;
			ser_pos_q  <= '0;
		end else if (adv) begin
			ser_busy_q <= vld_s[ND] && emit;
			ser_pos_q  <= '0;
			ser_ptr_q  <= meta_s[ND].fmt ? PTR_W'(FIXED_LEN - 1)
			                             : PTR_W'(meta_s[ND].cnt - COUNT_W'(1));
		end else begin
			ser_ptr_q <= ser_ptr_q - PTR_W'(1);
			ser_pos_q <= ser_pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SER_N; i++) begin
				if (meta_s[ND].fmt) begin
					case (i)
						4:       chr_q[i] <= to_char(dig_s[ND][1]);
						3:       chr_q[i] <= to_char(dig_s[ND][0]);
						2:       chr_q[i] <= CHAR_POINT;
						1:       chr_q[i] <= to_char(meta_s[ND].ftens);
						0:       chr_q[i] <= to_char(meta_s[ND].fones);
						default: chr_q[i] <= CHAR_ZERO;
					endcase
				end else if (i < ND) begin
					chr_q[i] <= to_char(dig_s[ND][i]);
				end else begin
					chr_q[i] <= CHAR_ZERO;
				end
			end
		end
	end

	assign strobe    = ser_busy_q;
	assign character = chr_q[ser_ptr_q];
	assign position  = ser_pos_q;
	assign last      = ser_busy_q && (ser_ptr_q == '0);

	// A number's beats leave back to back
	a_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("beat gap inside a number");

	// Positions count up by one within a number
	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> position == ($past(position) + POS_W'(1)))
		else $error("position did not advance by one");

	// Hold off new numbers only while a number still owns more beats
	a_busy_only_mid_number: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe && !last)
		else $error("busy without pending beats");

	// A new number starts at position zero
	a_first_position: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !$past(strobe && !last) |-> position == '0)
		else $error("number did not start at position zero");

endmodule
